[rtl/gravity_velocity_step_defines.svh]
// ---------------------------------------------------------------------------
// Gravity velocity step: assertion macros
// Concurrent check macros, clocked on i_clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef GRAVITY_VELOCITY_STEP_DEFINES_SVH
`define GRAVITY_VELOCITY_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define GVS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gvs: check failed");
`define GVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gvs: check failed");
`else
`define GVS_ASSERT_NOW(lbl, ante, cons)
`define GVS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/gvs_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gravity velocity step package
// Shared types, codes, constants and helpers of the controller and datapath.
// ---------------------------------------------------------------------------
package gvs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_KICK,
        CMD_NUDGE
    } t_command;

    typedef enum logic [1:0] {
        REG_GCONST,
        REG_TSTEP,
        REG_MAXSPD,
        REG_CONTACT
    } t_reg_idx;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_SEP,
        UOP_MUL_AXAX,
        UOP_MUL_AYAY,
        UOP_SQRT_R2,
        UOP_MUL_DD,
        UOP_MUL_D2D,
        UOP_MUL_GM,
        UOP_MUL_GMDT,
        UOP_MUL_KAX,
        UOP_DIV_X,
        UOP_MUL_KAY,
        UOP_DIV_Y,
        UOP_KICK,
        UOP_NUDGE,
        UOP_MUL_V2X,
        UOP_MUL_V2Y,
        UOP_CLAMP_CHK,
        UOP_SQRT_V2,
        UOP_SQRT_LIM,
        UOP_MUL_AXM,
        UOP_DIV_AXW,
        UOP_MUL_AYM,
        UOP_DIV_AYW,
        UOP_CLAMP_APPLY
    } t_uop;

    typedef struct packed {
        logic capture;
        logic issue;
        t_uop uop;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic zero_sep;
        logic over;
    } t_dp_stat;

    localparam logic [5:0]  MUL_STEPS  = 6'd33;
    localparam logic [5:0]  SQRT_STEPS = 6'd33;
    localparam logic [5:0]  DIV_STEPS  = 6'd33;
    localparam logic [32:0] KICK_SAT   = 33'h1_0000_0000;

    localparam logic [31:0] GCONST_RESET  = 32'd65536;
    localparam logic [31:0] TSTEP_RESET   = 32'd1092;
    localparam logic [31:0] MAXSPD_RESET  = 32'hFFFF_FFFF;
    localparam logic [15:0] CONTACT_RESET = 16'd40;

    function automatic logic [31:0] f_sat32(input logic [34:0] v);
        logic [31:0] r;
        if (!v[34] && (v[33:31] != 3'b000)) begin
            r = 32'h7FFF_FFFF;
        end else if (v[34] && (v[33:31] != 3'b111)) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/gravity_velocity_step.sv]
`timescale 1ns / 1ps
// Requests: one at a time; each multiply, square root or divide step runs on the
// shared bit-serial units.
// Reset: synchronous, active low; restores register defaults and zeroes the target.
// ---------------------------------------------------------------------------
// Gravity velocity step
// Loads one target body and applies pairwise gravity kicks and nudges to its velocity,
// with a speed limit and a contact test.
// ---------------------------------------------------------------------------
module gravity_velocity_step
    import gvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x, pos_y, body_mass, vel_x, vel_y
    input  logic [159:0] i_s_tdata,
    // command
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_vel_x, out_vel_y
    output logic [63:0]  o_m_tdata,
    // hit, clamped, zero_sep
    output logic [2:0]   o_m_tuser
);

    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_dp_stat;
    logic [31:0] w_out_vx, w_out_vy;
    logic        w_hit, w_clamped, w_zero;

    gvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_command  (t_command'(i_s_tuser)),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_dp_cmd   (w_dp_cmd),
        .i_dp_stat  (w_dp_stat)
    );

    gvs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pos_x     (i_s_tdata[31:0]),
        .i_pos_y     (i_s_tdata[63:32]),
        .i_body_mass (i_s_tdata[95:64]),
        .i_vel_x     (i_s_tdata[127:96]),
        .i_vel_y     (i_s_tdata[159:128]),
        .i_dp_cmd    (w_dp_cmd),
        .o_dp_stat   (w_dp_stat),
        .o_out_vel_x (w_out_vx),
        .o_out_vel_y (w_out_vy),
        .o_hit       (w_hit),
        .o_clamped   (w_clamped),
        .o_zero_sep  (w_zero)
    );

    assign o_m_tdata = {w_out_vy, w_out_vx};
    assign o_m_tuser = {w_zero, w_clamped, w_hit};

endmodule

[rtl/gvs_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gravity velocity step controller
// Sequences the datapath micro-operations of each request and owns the
// handshakes of both stream sides.
// ---------------------------------------------------------------------------
`include "gravity_velocity_step_defines.svh"

module gvs_ctrl
    import gvs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_command i_command,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_dp_cmd  o_dp_cmd,
    input  t_dp_stat i_dp_stat
);

    t_state  r_state, n_state;
    t_uop    r_step, n_step;
    t_uop    w_next;
    logic    r_out_valid;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= UOP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        case (r_step)
            UOP_SEP:         w_next = i_dp_stat.zero_sep ? UOP_NONE : UOP_MUL_AXAX;
            UOP_MUL_AXAX:    w_next = UOP_MUL_AYAY;
            UOP_MUL_AYAY:    w_next = UOP_SQRT_R2;
            UOP_SQRT_R2:     w_next = UOP_MUL_DD;
            UOP_MUL_DD:      w_next = UOP_MUL_D2D;
            UOP_MUL_D2D:     w_next = UOP_MUL_GM;
            UOP_MUL_GM:      w_next = UOP_MUL_GMDT;
            UOP_MUL_GMDT:    w_next = UOP_MUL_KAX;
            UOP_MUL_KAX:     w_next = UOP_DIV_X;
            UOP_DIV_X:       w_next = UOP_MUL_KAY;
            UOP_MUL_KAY:     w_next = UOP_DIV_Y;
            UOP_DIV_Y:       w_next = UOP_KICK;
            UOP_KICK:        w_next = UOP_MUL_V2X;
            UOP_NUDGE:       w_next = UOP_MUL_V2X;
            UOP_MUL_V2X:     w_next = UOP_MUL_V2Y;
            UOP_MUL_V2Y:     w_next = UOP_CLAMP_CHK;
            UOP_CLAMP_CHK:   w_next = i_dp_stat.over ? UOP_SQRT_V2 : UOP_NONE;
            UOP_SQRT_V2:     w_next = UOP_SQRT_LIM;
            UOP_SQRT_LIM:    w_next = UOP_MUL_AXM;
            UOP_MUL_AXM:     w_next = UOP_DIV_AXW;
            UOP_DIV_AXW:     w_next = UOP_MUL_AYM;
            UOP_MUL_AYM:     w_next = UOP_DIV_AYW;
            UOP_DIV_AYW:     w_next = UOP_CLAMP_APPLY;
            default:         w_next = UOP_NONE;
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        w_cmd.capture  = 1'b0;
        w_cmd.issue    = 1'b0;
        w_cmd.uop      = r_step;
        w_cmd.out_load = 1'b0;
        o_s_tready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    w_cmd.capture = 1'b1;
                    case (i_command)
                        CMD_LOAD:  n_step = UOP_LOAD;
                        CMD_KICK:  n_step = UOP_SEP;
                        CMD_NUDGE: n_step = UOP_NUDGE;
                        default:   n_step = UOP_NONE;
                    endcase
                    n_state = (n_step == UOP_NONE) ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                w_cmd.issue = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_dp_stat.busy) begin
                    n_step  = w_next;
                    n_state = (w_next == UOP_NONE) ? ST_OUT : ST_ISSUE;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_dp_cmd   = w_cmd;
    assign o_m_tvalid = r_out_valid;

    `GVS_ASSERT_NEXT(a_accept_leaves_idle, i_s_tvalid && o_s_tready, r_state != ST_IDLE)
    `GVS_ASSERT_NOW(a_issue_when_free, w_cmd.issue, !i_dp_stat.busy)
    `GVS_ASSERT_NEXT(a_result_held, (r_state == ST_OUT) && r_out_valid && !i_m_tready, (r_state == ST_OUT) && r_out_valid)

endmodule

[rtl/gvs_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gravity velocity step datapath
// Target state, configuration registers and a shared shift-add multiplier,
// bit-pair square root and restoring divider driven by micro-operations.
// ---------------------------------------------------------------------------
module gvs_datapath
    import gvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_body_mass,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  t_dp_cmd     i_dp_cmd,
    output t_dp_stat    o_dp_stat,
    output logic [31:0] o_out_vel_x,
    output logic [31:0] o_out_vel_y,
    output logic        o_hit,
    output logic        o_clamped,
    output logic        o_zero_sep
);

    logic [31:0] r_gconst, r_tstep, r_maxspd;
    logic [15:0] r_contact;
    logic [31:0] r_tx, r_ty, r_vx, r_vy;
    logic        r_sxn, r_syn, r_zero, r_hit, r_clamped, r_over;

    logic [31:0] r_in_px, r_in_py, r_in_mass, r_in_dvx, r_in_dvy;
    logic [32:0] r_ax, r_ay, r_d, r_kx, r_w, r_m;
    logic [65:0] r_r2;
    logic [98:0] r_d3;
    logic [95:0] r_k;
    logic [31:0] r_o_vx, r_o_vy;
    logic        r_o_hit, r_o_clamped, r_o_zero;

    logic [128:0] r_mul_a, r_mul_acc;
    logic [32:0]  r_mul_b;
    logic [5:0]   r_mul_cnt;
    logic         r_mul_busy;

    logic [65:0] r_sq_n;
    logic [34:0] r_sq_rem;
    logic [32:0] r_sq_root;
    logic [5:0]  r_sq_cnt;
    logic        r_sq_busy;

    logic [32:0] r_dv_num;
    logic [98:0] r_dv_rem, r_dv_den;
    logic [32:0] r_dv_q;
    logic        r_dv_sat;
    logic [5:0]  r_dv_cnt;
    logic        r_dv_busy;

    logic         w_mul_start, w_sq_start, w_dv_start;
    logic [95:0]  w_mul_a;
    logic [32:0]  w_mul_b;
    logic [65:0]  w_sq_in;
    logic [127:0] w_dv_num;
    logic [98:0]  w_dv_den;

    logic [32:0] w_sx, w_sy, w_ax, w_ay, w_vxm, w_vym;
    logic [65:0] w_r2s, w_lim;
    logic [31:0] w_cd_sq;
    logic [32:0] w_q_sat, w_negkx, w_negq;
    logic [34:0] w_vx35, w_vy35, w_kx35, w_ky35;
    logic [31:0] w_kick_x, w_kick_y, w_nudge_x, w_nudge_y;

    logic [36:0] w_sq_sh, w_sq_trial, w_sq_diff;
    logic        w_sq_ge;
    logic [99:0] w_dv_sh, w_dv_diff;
    logic        w_dv_ge;

    assign w_sx    = {r_tx[31], r_tx} - {r_in_px[31], r_in_px};
    assign w_sy    = {r_ty[31], r_ty} - {r_in_py[31], r_in_py};
    assign w_ax    = w_sx[32] ? (33'd0 - w_sx) : w_sx;
    assign w_ay    = w_sy[32] ? (33'd0 - w_sy) : w_sy;
    assign w_vxm   = r_vx[31] ? (33'd0 - {r_vx[31], r_vx}) : {1'b0, r_vx};
    assign w_vym   = r_vy[31] ? (33'd0 - {r_vy[31], r_vy}) : {1'b0, r_vy};
    assign w_r2s   = r_r2 + r_mul_acc[65:0];
    assign w_lim   = {2'b00, r_maxspd, 32'd0};
    assign w_cd_sq = {16'd0, r_contact} * {16'd0, r_contact};

    assign w_q_sat = (r_dv_sat || (r_dv_q > KICK_SAT)) ? KICK_SAT : r_dv_q;
    assign w_negkx = 33'd0 - r_kx;
    assign w_negq  = 33'd0 - w_q_sat;

    assign w_vx35    = {{3{r_vx[31]}}, r_vx};
    assign w_vy35    = {{3{r_vy[31]}}, r_vy};
    assign w_kx35    = {2'b00, r_kx};
    assign w_ky35    = {2'b00, w_q_sat};
    assign w_kick_x  = f_sat32(r_sxn ? (w_vx35 + w_kx35) : (w_vx35 - w_kx35));
    assign w_kick_y  = f_sat32(r_syn ? (w_vy35 + w_ky35) : (w_vy35 - w_ky35));
    assign w_nudge_x = f_sat32(w_vx35 + {{3{r_in_dvx[31]}}, r_in_dvx});
    assign w_nudge_y = f_sat32(w_vy35 + {{3{r_in_dvy[31]}}, r_in_dvy});

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_sq_start  = 1'b0;
        w_sq_in     = '0;
        w_dv_start  = 1'b0;
        w_dv_num    = '0;
        w_dv_den    = '0;
        if (i_dp_cmd.issue) begin
            case (i_dp_cmd.uop)
                UOP_MUL_AXAX: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, r_ax};
                    w_mul_b     = r_ax;
                end
                UOP_MUL_AYAY, UOP_MUL_V2Y: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, r_ay};
                    w_mul_b     = r_ay;
                end
                UOP_SQRT_R2: begin
                    w_sq_start = 1'b1;
                    w_sq_in    = w_r2s;
                end
                UOP_MUL_DD: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, r_sq_root};
                    w_mul_b     = r_sq_root;
                end
                UOP_MUL_D2D: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {30'd0, r_mul_acc[65:0]};
                    w_mul_b     = r_d;
                end
                UOP_MUL_GM: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {64'd0, r_gconst};
                    w_mul_b     = {1'b0, r_in_mass};
                end
                UOP_MUL_GMDT: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {32'd0, r_mul_acc[63:0]};
                    w_mul_b     = {1'b0, r_tstep};
                end
                UOP_MUL_KAX: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_mul_acc[95:0];
                    w_mul_b     = r_ax;
                end
                UOP_MUL_KAY: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_k;
                    w_mul_b     = r_ay;
                end
                UOP_DIV_X, UOP_DIV_Y: begin
                    w_dv_start = 1'b1;
                    w_dv_num   = r_mul_acc[127:0];
                    w_dv_den   = r_d3;
                end
                UOP_MUL_V2X: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, w_vxm};
                    w_mul_b     = w_vxm;
                end
                UOP_SQRT_V2: begin
                    w_sq_start = 1'b1;
                    w_sq_in    = r_r2;
                end
                UOP_SQRT_LIM: begin
                    w_sq_start = 1'b1;
                    w_sq_in    = w_lim;
                end
                UOP_MUL_AXM: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, r_ax};
                    w_mul_b     = r_sq_root;
                end
                UOP_MUL_AYM: begin
                    w_mul_start = 1'b1;
                    w_mul_a     = {63'd0, r_ay};
                    w_mul_b     = r_m;
                end
                UOP_DIV_AXW, UOP_DIV_AYW: begin
                    w_dv_start = 1'b1;
                    w_dv_num   = r_mul_acc[127:0];
                    w_dv_den   = {66'd0, r_w};
                end
                default: begin
                    w_mul_start = 1'b0;
                end
            endcase
        end
    end

    // Target state, configuration and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gconst  <= GCONST_RESET;
            r_tstep   <= TSTEP_RESET;
            r_maxspd  <= MAXSPD_RESET;
            r_contact <= CONTACT_RESET;
            r_tx      <= '0;
            r_ty      <= '0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_sxn     <= 1'b0;
            r_syn     <= 1'b0;
            r_zero    <= 1'b0;
            r_hit     <= 1'b0;
            r_clamped <= 1'b0;
            r_over    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_GCONST:  r_gconst  <= i_cfg_wdata;
                    REG_TSTEP:   r_tstep   <= i_cfg_wdata;
                    REG_MAXSPD:  r_maxspd  <= i_cfg_wdata;
                    REG_CONTACT: r_contact <= i_cfg_wdata[15:0];
                    default:     r_contact <= r_contact;
                endcase
            end
            if (i_dp_cmd.capture) begin
                r_zero    <= 1'b0;
                r_hit     <= 1'b0;
                r_clamped <= 1'b0;
                r_over    <= 1'b0;
            end
            if (i_dp_cmd.issue) begin
                case (i_dp_cmd.uop)
                    UOP_LOAD: begin
                        r_tx <= r_in_px;
                        r_ty <= r_in_py;
                        r_vx <= r_in_dvx;
                        r_vy <= r_in_dvy;
                    end
                    UOP_SEP: begin
                        r_sxn <= w_sx[32];
                        r_syn <= w_sy[32];
                        if ((w_ax == 33'd0) && (w_ay == 33'd0)) begin
                            r_zero <= 1'b1;
                            r_hit  <= (r_contact != 16'd0);
                        end
                    end
                    UOP_SQRT_R2: begin
                        r_hit <= (w_r2s < {2'b00, w_cd_sq, 32'd0});
                    end
                    UOP_KICK: begin
                        r_vx <= w_kick_x;
                        r_vy <= w_kick_y;
                    end
                    UOP_NUDGE: begin
                        r_vx <= w_nudge_x;
                        r_vy <= w_nudge_y;
                    end
                    UOP_CLAMP_CHK: begin
                        r_over <= (w_r2s > w_lim);
                    end
                    UOP_CLAMP_APPLY: begin
                        r_vx      <= r_vx[31] ? w_negkx[31:0] : r_kx[31:0];
                        r_vy      <= r_vy[31] ? w_negq[31:0] : w_q_sat[31:0];
                        r_clamped <= 1'b1;
                    end
                    default: r_over <= r_over;
                endcase
            end
        end
    end

    // Request payload and intermediate operands.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_in_px   <= i_pos_x;
            r_in_py   <= i_pos_y;
            r_in_mass <= i_body_mass;
            r_in_dvx  <= i_vel_x;
            r_in_dvy  <= i_vel_y;
        end
        if (i_dp_cmd.issue) begin
            case (i_dp_cmd.uop)
                UOP_SEP: begin
                    r_ax <= w_ax;
                    r_ay <= w_ay;
                end
                UOP_MUL_AYAY, UOP_MUL_V2Y: r_r2 <= r_mul_acc[65:0];
                UOP_SQRT_R2:               r_r2 <= w_r2s;
                UOP_MUL_DD:                r_d  <= r_sq_root;
                UOP_MUL_GM:                r_d3 <= r_mul_acc[98:0];
                UOP_MUL_KAX:               r_k  <= r_mul_acc[95:0];
                UOP_MUL_KAY, UOP_MUL_AYM:  r_kx <= w_q_sat;
                UOP_MUL_V2X: begin
                    r_ax <= w_vxm;
                    r_ay <= w_vym;
                end
                UOP_CLAMP_CHK:             r_r2 <= w_r2s;
                UOP_SQRT_LIM:              r_w  <= r_sq_root;
                UOP_MUL_AXM:               r_m  <= r_sq_root;
                default:                   r_d  <= r_d;
            endcase
        end
        if (i_dp_cmd.out_load) begin
            r_o_vx      <= r_vx;
            r_o_vy      <= r_vy;
            r_o_hit     <= r_hit;
            r_o_clamped <= r_clamped;
            r_o_zero    <= r_zero;
        end
    end

    // Shift-add multiplier, one multiplier bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_cnt  <= '0;
        end else if (w_mul_start) begin
            r_mul_busy <= 1'b1;
            r_mul_cnt  <= MUL_STEPS;
        end else if (r_mul_busy) begin
            r_mul_busy <= (r_mul_cnt != 6'd1);
            r_mul_cnt  <= r_mul_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_start) begin
            r_mul_a   <= {33'd0, w_mul_a};
            r_mul_b   <= w_mul_b;
            r_mul_acc <= '0;
        end else if (r_mul_busy) begin
            if (r_mul_b[0]) begin
                r_mul_acc <= r_mul_acc + r_mul_a;
            end
            r_mul_a <= {r_mul_a[127:0], 1'b0};
            r_mul_b <= {1'b0, r_mul_b[32:1]};
        end
    end

    // Square root, one bit pair of the radicand a cycle.
    assign w_sq_sh    = {r_sq_rem, r_sq_n[65:64]};
    assign w_sq_trial = {2'b00, r_sq_root, 2'b01};
    assign w_sq_ge    = (w_sq_sh >= w_sq_trial);
    assign w_sq_diff  = w_sq_sh - w_sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (w_sq_start) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= SQRT_STEPS;
        end else if (r_sq_busy) begin
            r_sq_busy <= (r_sq_cnt != 6'd1);
            r_sq_cnt  <= r_sq_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sq_start) begin
            r_sq_n    <= w_sq_in;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_busy) begin
            r_sq_n    <= {r_sq_n[63:0], 2'b00};
            r_sq_rem  <= w_sq_ge ? w_sq_diff[34:0] : w_sq_sh[34:0];
            r_sq_root <= {r_sq_root[31:0], w_sq_ge};
        end
    end

    // Restoring divider for a quotient below 2^33; larger ones saturate.
    assign w_dv_sh   = {r_dv_rem, r_dv_num[32]};
    assign w_dv_ge   = (w_dv_sh >= {1'b0, r_dv_den});
    assign w_dv_diff = w_dv_sh - {1'b0, r_dv_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (w_dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= DIV_STEPS;
        end else if (r_dv_busy) begin
            r_dv_busy <= (r_dv_cnt != 6'd1);
            r_dv_cnt  <= r_dv_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_start) begin
            r_dv_rem <= {4'd0, w_dv_num[127:33]};
            r_dv_num <= w_dv_num[32:0];
            r_dv_den <= w_dv_den;
            r_dv_q   <= '0;
            r_dv_sat <= ({4'd0, w_dv_num} >= {w_dv_den, 33'd0});
        end else if (r_dv_busy) begin
            r_dv_rem <= w_dv_ge ? w_dv_diff[98:0] : w_dv_sh[98:0];
            r_dv_num <= {r_dv_num[31:0], 1'b0};
            r_dv_q   <= {r_dv_q[31:0], w_dv_ge};
        end
    end

    assign o_dp_stat.busy     = r_mul_busy | r_sq_busy | r_dv_busy;
    assign o_dp_stat.zero_sep = r_zero;
    assign o_dp_stat.over     = r_over;

    assign o_out_vel_x = r_o_vx;
    assign o_out_vel_y = r_o_vy;
    assign o_hit       = r_o_hit;
    assign o_clamped   = r_o_clamped;
    assign o_zero_sep  = r_o_zero;

endmodule
